FILE: rtl/core/led_pkg.sv
// Shared constants and types for the line editor discipline block.
package led_pkg;

	// Field widths.
	localparam int BYTE_W = 8;
	localparam int KIND_W = 3;
	localparam int CHAR_W = 7;
	localparam int LEN_W  = 6;

	// Default line capacity (1 to 63).
	localparam int LINE_CAPACITY_DEF = 40;

	// Key codes.
	localparam logic [BYTE_W-1:0] KEY_ERASE = 8'd127;
	localparam logic [BYTE_W-1:0] KEY_KILL  = 8'd21;
	localparam logic [BYTE_W-1:0] KEY_WORD  = 8'd23;
	localparam logic [BYTE_W-1:0] KEY_EOT   = 8'd4;
	localparam logic [CHAR_W-1:0] KEY_SPACE = 7'd32;

	// Action codes.
	localparam logic [KIND_W-1:0] KIND_ECHO    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ERASE   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BELL    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_NEWLINE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_END     = 3'd4;

	// Control strobes from the sequencer to the line store.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} st_ctl_t;

endpackage

FILE: rtl/core/led_store.sv
// Line store memory with one write port and one registered read port.
module led_store
	import led_pkg::*;
#(
	parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
	parameter int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1
) (
	input  logic              clk,
	input  st_ctl_t           ctl,
	input  logic [AW-1:0]     wr_addr,
	input  logic [CHAR_W-1:0] wr_data,
	input  logic [AW-1:0]     rd_addr,
	output logic [CHAR_W-1:0] rd_data
);

	logic [CHAR_W-1:0] mem_q [LINE_CAPACITY];

	// Write port.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/core/led_seq.sv
// Sequencer that decodes each typed byte, walks the line store and drives the output register.
module led_seq
	import led_pkg::*;
#(
	parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
	parameter int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [KIND_W-1:0] out_kind,
	output logic [BYTE_W-1:0] out_byte,
	output logic              last,
	output st_ctl_t           st_ctl,
	output logic [AW-1:0]     st_wr_addr,
	output logic [CHAR_W-1:0] st_wr_data,
	output logic [AW-1:0]     st_rd_addr,
	input  logic [CHAR_W-1:0] st_rd_data
);

	localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_CAPACITY);
	localparam logic [LEN_W-1:0] ONE = LEN_W'(1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ONE   = 3'd1;
	localparam logic [2:0] S_ECHO  = 3'd2;
	localparam logic [2:0] S_KILL  = 3'd3;
	localparam logic [2:0] S_WREAD = 3'd4;
	localparam logic [2:0] S_WCHK  = 3'd5;
	localparam logic [2:0] S_WLAST = 3'd6;

	logic [2:0]        state_q, state_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic              session_q, session_d;
	logic              phase_q, phase_d;     // 0 while removing spaces, 1 inside the word
	logic              pending_q, pending_d; // a decided removal waits to be reported
	logic [KIND_W-1:0] kind_q, kind_d;
	logic [BYTE_W-1:0] byte_q, byte_d;

	logic              emit;
	logic [KIND_W-1:0] e_kind;
	logic [BYTE_W-1:0] e_byte;
	logic              e_last;
	logic              out_free;
	logic [LEN_W-1:0]  len_dec;
	logic              is_ctrl;
	logic              is_sp;
	logic              remove;

	assign out_free   = !out_valid || !out_stall;
	assign len_dec    = len_q - ONE;
	assign is_ctrl    = in_byte[7] || (in_byte[7:5] == 3'd0);
	assign in_stall   = (state_q != S_IDLE);
	assign st_wr_addr = len_q[AW-1:0];
	assign st_wr_data = in_byte[CHAR_W-1:0];
	assign st_rd_addr = len_dec[AW-1:0];

	// Compare unit for word erase: is the tail character a space, and does it go.
	assign is_sp  = (st_rd_data == KEY_SPACE);
	assign remove = !phase_q || !is_sp;

	// Next-state and action logic.
	always_comb begin
		state_d       = state_q;
		len_d         = len_q;
		session_d     = session_q;
		phase_d       = phase_q;
		pending_d     = pending_q;
		kind_d        = kind_q;
		byte_d        = byte_q;
		emit          = 1'b0;
		e_kind        = KIND_ERASE;
		e_byte        = '0;
		e_last        = 1'b1;
		st_ctl.wr_en  = 1'b0;
		st_ctl.rd_en  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && !session_q) begin
					priority if (in_byte == KEY_EOT && len_q == '0) begin
						session_d = 1'b1;
						kind_d    = KIND_END;
						state_d   = S_ONE;
					end else if (in_byte == KEY_ERASE) begin
						if (len_q != '0) begin
							len_d   = len_dec;
							kind_d  = KIND_ERASE;
							state_d = S_ONE;
						end
					end else if (in_byte == KEY_KILL) begin
						if (len_q != '0) begin
							state_d = S_KILL;
						end
					end else if (in_byte == KEY_WORD) begin
						if (len_q != '0) begin
							phase_d   = 1'b0;
							pending_d = 1'b0;
							state_d   = S_WREAD;
						end
					end else if (is_ctrl) begin
						kind_d  = KIND_BELL;
						state_d = S_ONE;
					end else if (len_q != CAP) begin
						st_ctl.wr_en = 1'b1;
						len_d        = len_q + ONE;
						byte_d       = in_byte;
						state_d      = S_ECHO;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_ONE: begin
				if (out_free) begin
					emit    = 1'b1;
					e_kind  = kind_q;
					state_d = S_IDLE;
				end
			end
			S_ECHO: begin
				if (out_free) begin
					emit   = 1'b1;
					e_kind = KIND_ECHO;
					e_byte = byte_q;
					e_last = (len_q != CAP);
					if (len_q == CAP) begin
						kind_d  = KIND_NEWLINE;
						state_d = S_ONE;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_KILL: begin
				if (out_free) begin
					emit   = 1'b1;
					e_last = (len_q == ONE);
					len_d  = len_dec;
					if (len_q == ONE) begin
						state_d = S_IDLE;
					end
				end
			end
			S_WREAD: begin
				st_ctl.rd_en = 1'b1;
				state_d      = S_WCHK;
			end
			S_WCHK: begin
				// A removal reports the one decided before it, so it needs the output free when one is pending.
				if (!remove) begin
					state_d = S_WLAST;
				end else if (!pending_q || out_free) begin
					emit      = pending_q;
					e_last    = 1'b0;
					len_d     = len_dec;
					pending_d = 1'b1;
					if (!is_sp) begin
						phase_d = 1'b1;
					end
					state_d = (len_q == ONE) ? S_WLAST : S_WREAD;
				end
			end
			S_WLAST: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			len_q     <= '0;
			session_q <= 1'b0;
			phase_q   <= 1'b0;
			pending_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			len_q     <= len_d;
			session_q <= session_d;
			phase_q   <= phase_d;
			pending_q <= pending_d;
			if (emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		kind_q <= kind_d;
		byte_q <= byte_d;
		if (emit) begin
			out_kind <= e_kind;
			out_byte <= e_byte;
			last     <= e_last;
		end
	end

endmodule

FILE: rtl/core/line_editor_discipline_top.sv
// Top level of the line editor discipline block.
//
// One typed byte enters on the input channel (in_valid, in_stall, in_byte).
// Terminal actions leave on the output channel (out_valid, out_stall,
// out_kind, out_byte, last), one request per action; last marks the final
// action caused by a byte. A byte that causes no action gives no request.
// in_stall is high from the cycle after a byte is taken until its last
// action has been loaded into the output register.
// The first action of a byte is loaded into the output register from the
// state that the byte leads to, once the output is free; word erase first
// reads the store and checks the tail character. Kill gives one erase per
// cycle while the output does not stall. Word erase reads the line store
// once for each character that it checks, through the single read port of
// the store: it reads in S_WREAD and checks in S_WCHK before the next read.
// A stalled output holds its request and the sequencer waits for it.
// Reset empties the line and reopens the session; the store contents are
// left as they are. After a session-ended action all bytes are dropped
// until the next reset.
module line_editor_discipline_top
	import led_pkg::*;
#(
	parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [KIND_W-1:0] out_kind,
	output logic [BYTE_W-1:0] out_byte,
	output logic              last
);

	localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

	st_ctl_t           st_ctl;
	logic [AW-1:0]     st_wr_addr;
	logic [AW-1:0]     st_rd_addr;
	logic [CHAR_W-1:0] st_wr_data;
	logic [CHAR_W-1:0] st_rd_data;

	// Sequencer with the output register.
	led_seq #(
		.LINE_CAPACITY(LINE_CAPACITY),
		.AW(AW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_kind(out_kind),
		.out_byte(out_byte),
		.last(last),
		.st_ctl(st_ctl),
		.st_wr_addr(st_wr_addr),
		.st_wr_data(st_wr_data),
		.st_rd_addr(st_rd_addr),
		.st_rd_data(st_rd_data)
	);

	// Line store.
	led_store #(
		.LINE_CAPACITY(LINE_CAPACITY),
		.AW(AW)
	) u_store (
		.clk(clk),
		.ctl(st_ctl),
		.wr_addr(st_wr_addr),
		.wr_data(st_wr_data),
		.rd_addr(st_rd_addr),
		.rd_data(st_rd_data)
	);

endmodule

FILE: rtl/core/led_checker.sv
// Port-level checker for the line editor discipline block and its bind.
module led_checker
	import led_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [BYTE_W-1:0] in_byte,
	input logic              out_valid,
	input logic              out_stall,
	input logic [KIND_W-1:0] out_kind,
	input logic [BYTE_W-1:0] out_byte,
	input logic              last
);

	// A stalled input request keeps its byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_byte))
		else $error("stalled input request changed");

	// A stalled request keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_byte)
			&& $stable(last))
		else $error("stalled output request changed");

	// Only echo actions carry a byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_ECHO |-> out_byte == '0)
		else $error("non-echo action carries a byte");

	// Bell, newline and session end always close the actions of a byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_BELL || out_kind == KIND_NEWLINE
			|| out_kind == KIND_END) |-> last)
		else $error("closing action without last");

	// Nothing follows the session-ended action.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_kind == KIND_END |=> !out_valid)
		else $error("action after session end");

endmodule

bind line_editor_discipline_top led_checker u_led_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.in_byte(in_byte),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_kind(out_kind),
	.out_byte(out_byte),
	.last(last)
);

FILE: dv/line_editor_discipline_checker.sv
// Checker for the line editor discipline block: predicts terminal actions and compares them.
module line_editor_discipline_checker
	import led_pkg::*;
#(
	parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [KIND_W-1:0] out_kind,
	input  logic [BYTE_W-1:0] out_byte,
	input  logic              last,
	output int                mismatches,
	output int                pending
);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] data;
		logic              last;
	} action_t;

	// Predicted screen actions that have not yet left the block, oldest first.
	action_t screen_actions[$];

	// Shadow copy of the line and the session state.
	logic [CHAR_W-1:0] line_chars [LINE_CAPACITY];
	int unsigned       line_fill;
	bit                session_done;
	int                miss_count;

	initial begin
		miss_count = 0;
	end

	task automatic report_mismatch(input string msg);
		miss_count++;
		$display("%0t: mismatch: %s", $time, msg);
	endtask

	task automatic push_action(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data);
		action_t a;
		a.kind = kind;
		a.data = data;
		a.last = 1'b0;
		screen_actions.push_back(a);
	endtask

	// Removes the last character of the line with one erase-column action.
	task automatic rub_out();
		line_fill--;
		push_action(KIND_ERASE, '0);
	endtask

	// Works out the actions caused by one typed byte and updates the line.
	task automatic edit_line(input logic [BYTE_W-1:0] key);
		int first;
		first = screen_actions.size();
		if (session_done)
			return;
		if (key == KEY_EOT && line_fill == 0) begin
			session_done = 1'b1;
			push_action(KIND_END, '0);
		end else if (key == KEY_ERASE) begin
			if (line_fill > 0)
				rub_out();
		end else if (key == KEY_KILL) begin
			while (line_fill > 0)
				rub_out();
		end else if (key == KEY_WORD) begin
			// Trailing spaces go first, then the word before them.
			while (line_fill > 0 && line_chars[line_fill-1] == KEY_SPACE)
				rub_out();
			while (line_fill > 0 && line_chars[line_fill-1] != KEY_SPACE)
				rub_out();
		end else if (key < 8'd32 || key >= 8'd128) begin
			push_action(KIND_BELL, '0);
		end else if (line_fill < LINE_CAPACITY) begin
			line_chars[line_fill] = key[CHAR_W-1:0];
			line_fill++;
			push_action(KIND_ECHO, key);
			if (line_fill == LINE_CAPACITY)
				push_action(KIND_NEWLINE, '0);
		end
		// A full line silently drops printable bytes, so nothing may be marked.
		if (screen_actions.size() > first)
			screen_actions[$].last = 1'b1;
	endtask

	// Compare each accepted action request, then predict from each accepted byte.
	always @(posedge clk or negedge arst_n) begin
		action_t want;
		if (!arst_n) begin
			line_fill    = 0;
			session_done = 1'b0;
			screen_actions.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (screen_actions.size() == 0) begin
					report_mismatch($sformatf("action kind %0d byte %0d with nothing pending",
						out_kind, out_byte));
				end else begin
					want = screen_actions.pop_front();
					if (out_kind !== want.kind)
						report_mismatch($sformatf("out_kind got %0d, expected %0d",
							out_kind, want.kind));
					if (out_byte !== want.data)
						report_mismatch($sformatf("out_byte got %0d, expected %0d",
							out_byte, want.data));
					if (last !== want.last)
						report_mismatch($sformatf("last got %0d, expected %0d",
							last, want.last));
				end
			end
			if (in_valid && !in_stall)
				edit_line(in_byte);
		end
		mismatches <= miss_count;
		pending    <= screen_actions.size();
	end

endmodule

FILE: dv/line_editor_discipline_top_tb.sv
// Testbench top for the line editor discipline block: clock, reset, stimulus and verdict.
module line_editor_discipline_top_tb;
	import led_pkg::*;

	localparam int LINE_CAP       = LINE_CAPACITY_DEF;
	localparam int ITEM_TARGET    = 320;
	localparam int CALM_FROM      = 270;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 2 * LINE_CAP + 20;
	localparam int WATCHDOG_LIMIT = 3000;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] in_byte   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [KIND_W-1:0] out_kind;
	logic [BYTE_W-1:0] out_byte;
	logic              last;

	int mismatches;
	int pending;
	int sent         = 0;
	int quiet_cycles = 0;
	bit calm         = 1'b0;
	bit hold_req     = 1'b0;
	// Set only while the line is known to hold at least one character.
	bit line_busy    = 1'b0;

	always #4 clk = ~clk;

	line_editor_discipline_top #(.LINE_CAPACITY(LINE_CAP)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_kind (out_kind),
		.out_byte (out_byte),
		.last     (last)
	);

	line_editor_discipline_checker #(.LINE_CAPACITY(LINE_CAP)) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.last      (last),
		.mismatches(mismatches),
		.pending   (pending)
	);

	// Watchdog: give up when no request moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: random stall bursts, plus one long hold-off to back up the input.
	initial begin
		bit held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offers one byte, with an occasional idle burst first, and waits until it is taken.
	task automatic send_key(input logic [BYTE_W-1:0] key);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= key;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		if (key >= 8'd32 && key <= 8'd126)
			line_busy = 1'b1;
		else if (key == KEY_ERASE || key == KEY_KILL || key == KEY_WORD)
			line_busy = 1'b0;
	endtask

	// A run of non-space printable characters, sometimes followed by spaces.
	task automatic type_word();
		repeat ($urandom_range(1, 8))
			send_key(8'($urandom_range(33, 126)));
		repeat ($urandom_range(0, 3))
			send_key(8'd32);
	endtask

	// Enough printable bytes to fill the line from any length, the rest dropped.
	task automatic fill_line();
		repeat ($urandom_range(LINE_CAP, LINE_CAP + 6))
			send_key(8'($urandom_range(32, 126)));
	endtask

	// Stimulus and verdict.
	initial begin
		int choice;
		logic [BYTE_W-1:0] noise;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Editing keys on an empty line cause nothing.
		send_key(KEY_ERASE);
		send_key(KEY_KILL);
		send_key(KEY_WORD);
		// Control bytes and high bytes ring the bell.
		send_key(8'd0);
		send_key(8'd1);
		send_key(8'd7);
		send_key(8'd31);
		send_key(8'd128);
		send_key(8'd255);
		// Printable extremes, then end of input on a non-empty line.
		send_key(8'd32);
		send_key(8'd126);
		send_key(KEY_EOT);
		// Word erase over trailing spaces and the word before them.
		send_key("a");
		send_key("b");
		send_key(8'd32);
		send_key(8'd32);
		send_key(KEY_WORD);
		send_key("x");
		send_key(KEY_ERASE);
		// Word erase on a line of spaces only.
		send_key(KEY_WORD);
		send_key("q");
		send_key("r");
		send_key(KEY_KILL);

		// Full line with newline and dropped bytes, under a long output hold-off.
		hold_req <= 1'b1;
		fill_line();
		send_key(KEY_WORD);

		// Random editing sessions, with no idling near the end.
		while (sent < ITEM_TARGET) begin
			if (sent >= CALM_FROM)
				calm = 1'b1;
			choice = $urandom_range(0, 39);
			if (choice < 18) begin
				type_word();
			end else if (choice < 22) begin
				repeat ($urandom_range(1, 3))
					send_key(KEY_ERASE);
			end else if (choice < 25) begin
				send_key(KEY_WORD);
			end else if (choice < 27) begin
				send_key(KEY_KILL);
			end else if (choice == 27) begin
				fill_line();
			end else if (choice < 30) begin
				send_key(line_busy ? KEY_EOT : 8'd7);
			end else begin
				noise = 8'($urandom_range(0, 255));
				if (noise == KEY_EOT && !line_busy)
					noise = 8'd7;
				send_key(noise);
			end
		end

		// End the session on an empty line; everything after it is ignored.
		calm = 1'b1;
		send_key(KEY_KILL);
		send_key(KEY_ERASE);
		send_key(KEY_EOT);
		send_key("z");
		send_key(KEY_EOT);
		send_key(8'd255);
		send_key(KEY_KILL);
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/led_pkg.sv
rtl/core/led_store.sv
rtl/core/led_seq.sv
rtl/core/line_editor_discipline_top.sv
rtl/core/led_checker.sv
dv/line_editor_discipline_checker.sv
dv/line_editor_discipline_top_tb.sv
